### rtl/bstv_pkg.sv
// Shared types and constants for the search tree validator.
`default_nettype none

package bstv_pkg;

	// Node table geometry
	localparam int unsigned MAX_NODES = 1024;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned KEY_W     = 64;

	// Key range limits as two's complement patterns
	localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	// Index constants
	localparam logic [IDX_W-1:0] ROOT_IDX = IDX_W'(1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_NODES);
	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_POST_ROOT = CNT_W'(2);

	// One node table entry: key and inherited bounds
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] lo;
		logic [KEY_W-1:0] hi;
	} bstv_entry_t;

endpackage

`default_nettype wire

### rtl/bst_incremental_validator_unit.sv
// Top level: incremental binary search tree validator with a node table memory.
// An accepted item passes the stage 1 register and then the output register.
// Throughput: one item per cycle while out_ready is high; the node table's single read port
// is read at acceptance and the previous item's write is forwarded to it.
// Reset sets the index counter to one and clears the violation flag and all valid
// flags; the node table is not cleared and only entries of the current tree are read.
`default_nettype none

module bst_incremental_validator_unit
	import bstv_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    is_root,
	input  wire logic signed [KEY_W-1:0] key_value,
	input  wire logic [IDX_W-1:0]        parent_index,
	input  wire logic                    goes_left,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         tree_valid,
	output logic [IDX_W-1:0]             assigned_index,
	output logic                         table_full
);

	// Node table
	bstv_entry_t node_mem [MAX_NODES];

	// Stage 1 state
	logic              v_s1;
	logic              root_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [IDX_W-1:0]  parent_s1;
	logic              left_s1;
	bstv_entry_t       rd_s1;
	logic              fwd_s1;
	bstv_entry_t       fwd_data_s1;

	// Architectural state
	logic [CNT_W-1:0]  next_q;
	logic              viol_q;

	// Output register
	logic              out_valid_q;
	logic              tree_valid_q;
	logic [IDX_W-1:0]  index_q;
	logic              full_q;

	// Stage 1 combinational results
	logic              accept;
	logic              adv;
	bstv_entry_t       pe;
	bstv_entry_t       wr_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [CNT_W-1:0]  next_n;
	logic              viol_n;
	logic              full_n;
	logic [IDX_W-1:0]  idx_n;
	logic              parent_ok;
	logic              order_bad;
	logic              bound_bad;
	logic [KEY_W-1:0]  lo_n;
	logic [KEY_W-1:0]  hi_n;

	// Handshake
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Take parent entry from forward register when the last write hit it
	assign pe = fwd_s1 ? fwd_data_s1 : rd_s1;

	// Evaluate the node against its parent and inherited bounds
	always_comb begin
		parent_ok = (parent_s1 != '0) && ({1'b0, parent_s1} < next_q);
		order_bad = 1'b0;
		bound_bad = 1'b0;
		lo_n      = KEY_MIN;
		hi_n      = KEY_MAX;
		wr_en     = 1'b0;
		wr_idx    = next_q[IDX_W-1:0];
		next_n    = next_q;
		viol_n    = viol_q;
		full_n    = 1'b0;
		idx_n     = next_q[IDX_W-1:0];
		if (parent_ok) begin
			if (left_s1) begin
				order_bad = !($signed(key_s1) < $signed(pe.key));
				lo_n      = pe.lo;
				hi_n      = (pe.key == KEY_MIN) ? KEY_MIN : pe.key - KEY_W'(1);
			end else begin
				order_bad = $signed(key_s1) < $signed(pe.key);
				lo_n      = pe.key;
				hi_n      = pe.hi;
			end
			bound_bad = ($signed(key_s1) < $signed(lo_n)) || ($signed(hi_n) < $signed(key_s1));
		end
		if (root_s1) begin
			wr_en  = 1'b1;
			wr_idx = ROOT_IDX;
			lo_n   = KEY_MIN;
			hi_n   = KEY_MAX;
			next_n = CNT_POST_ROOT;
			viol_n = 1'b0;
			idx_n  = ROOT_IDX;
		end else if (next_q >= CNT_FULL) begin
			viol_n = 1'b1;
			full_n = 1'b1;
			idx_n  = LAST_IDX;
		end else begin
			wr_en  = 1'b1;
			next_n = next_q + CNT_W'(1);
			viol_n = viol_q || !parent_ok || order_bad || bound_bad;
		end
		wr_data = '{key: key_s1, lo: lo_n, hi: hi_n};
	end

	// Table read at acceptance, write at stage 1 advance
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= node_mem[parent_index];
		end
		if (adv && wr_en) begin
			node_mem[wr_idx] <= wr_data;
		end
	end

	// Stage 1 payload and forward data
	always_ff @(posedge clk) begin
		if (accept) begin
			root_s1     <= is_root;
			key_s1      <= key_value;
			parent_s1   <= parent_index;
			left_s1     <= goes_left;
			fwd_data_s1 <= wr_data;
		end
	end

	// Stage 1 control, forward flag and tree state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			next_q <= CNT_INIT;
			viol_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1   <= 1'b1;
				fwd_s1 <= adv && wr_en && (parent_index == wr_idx);
			end else if (adv) begin
				v_s1   <= 1'b0;
				fwd_s1 <= 1'b0;
			end
			if (adv) begin
				next_q <= next_n;
				viol_q <= viol_n;
			end
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			tree_valid_q <= !viol_n;
			index_q      <= idx_n;
			full_q       <= full_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign tree_valid     = tree_valid_q;
	assign assigned_index = index_q;
	assign table_full     = full_q;

	// A root leaves the counter just past the root entry
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && root_s1 |=> next_q == CNT_POST_ROOT)
		else $error("counter wrong after root item");

	// A full table always marks the tree invalid
	a_full_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !tree_valid)
		else $error("full table reported as valid tree");

	// Counter stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_q != '0 && next_q <= CNT_FULL)
		else $error("node counter out of range");

	// Stalled input only while stage 1 holds an item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid_q)
		else $error("input stalled without a waiting item");

	// Forwarding only marks a live stage 1 item
	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward flag set with empty stage");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for the incremental binary search tree validator.
`timescale 1ns / 100ps

module tb
	import bstv_pkg::*;
;

	typedef struct {
		logic             tree_ok;
		logic [IDX_W-1:0] idx;
		logic             full;
	} tree_verdict_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    is_root = 1'b0;
	logic signed [KEY_W-1:0] key_value = '0;
	logic [IDX_W-1:0]        parent_index = '0;
	logic                    goes_left = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    tree_valid;
	logic [IDX_W-1:0]        assigned_index;
	logic                    table_full;

	// Shadow node table and tree status
	bstv_entry_t      shadow_tbl [MAX_NODES];
	logic [CNT_W-1:0] next_slot = CNT_INIT;
	logic             tree_broken = 1'b0;
	tree_verdict_t    verdict_q [$];
	int unsigned      err_cnt = 0;

	// Sender burst control
	bit          sender_steady = 1'b0;
	int unsigned burst_left = 0;

	// Receiver stall control
	bit          hold_off_req = 1'b0;
	int unsigned stall_left = 0;
	int unsigned rx_phase_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	logic [15:0] rx_mask = '1;

	bst_incremental_validator_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.is_root        (is_root),
		.key_value      (key_value),
		.parent_index   (parent_index),
		.goes_left      (goes_left),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tree_valid     (tree_valid),
		.assigned_index (assigned_index),
		.table_full     (table_full)
	);

	always #4 clk = ~clk;

	// Advance the shadow tree by one accepted node and queue its verdict
	task automatic track_node(input logic root, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] par, input logic left);
		logic [KEY_W-1:0] lo;
		logic [KEY_W-1:0] hi;
		logic [KEY_W-1:0] pk;
		logic [IDX_W-1:0] idx;
		logic             full;
		full = 1'b0;
		lo = KEY_MIN;
		hi = KEY_MAX;
		if (root) begin
			shadow_tbl[ROOT_IDX] = '{key: key, lo: KEY_MIN, hi: KEY_MAX};
			tree_broken = 1'b0;
			next_slot = CNT_POST_ROOT;
			idx = ROOT_IDX;
		end else if (next_slot >= CNT_FULL) begin
			full = 1'b1;
			tree_broken = 1'b1;
			idx = LAST_IDX;
		end else begin
			idx = next_slot[IDX_W-1:0];
			if (par == '0 || CNT_W'(par) >= next_slot) begin
				// parent not written yet in this tree
				tree_broken = 1'b1;
			end else begin
				pk = shadow_tbl[par].key;
				if (left) begin
					if (!($signed(key) < $signed(pk)))
						tree_broken = 1'b1;
					lo = shadow_tbl[par].lo;
					hi = (pk == KEY_MIN) ? KEY_MIN : pk - 1'b1;
				end else begin
					if ($signed(key) < $signed(pk))
						tree_broken = 1'b1;
					lo = pk;
					hi = shadow_tbl[par].hi;
				end
				if ($signed(key) < $signed(lo) || $signed(hi) < $signed(key))
					tree_broken = 1'b1;
			end
			shadow_tbl[idx] = '{key: key, lo: lo, hi: hi};
			next_slot = next_slot + 1'b1;
		end
		verdict_q.push_back('{tree_ok: !tree_broken, idx: idx, full: full});
	endtask

	// Predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		tree_verdict_t want;
		if (arst_n && in_valid && in_ready)
			track_node(is_root, key_value, parent_index, goes_left);
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result: tree_valid=%0b assigned_index=%0d table_full=%0b",
					tree_valid, assigned_index, table_full);
				err_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (tree_valid !== want.tree_ok) begin
					$error("tree_valid: expected %0b, got %0b", want.tree_ok, tree_valid);
					err_cnt++;
				end
				if (assigned_index !== want.idx) begin
					$error("assigned_index: expected %0d, got %0d", want.idx, assigned_index);
					err_cnt++;
				end
				if (table_full !== want.full) begin
					$error("table_full: expected %0b, got %0b", want.full, table_full);
					err_cnt++;
				end
			end
		end
	end

	// Drive out_ready: long hold on request, otherwise a changing pattern
	always @(negedge clk) begin
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			stall_left = 300;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_phase_left = $urandom_range(16, 96);
				rx_mask = 16'($urandom);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_FREE:    out_ready <= 1'b1;
				RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
				default:    out_ready <= rx_mask[rx_phase_left % 16];
			endcase
		end
	end

	// Offer one item from a falling edge; return at the falling edge after acceptance
	task automatic send_node(input logic root, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] par, input logic left);
		int unsigned gap;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left--;
		end
		in_valid     <= 1'b1;
		is_root      <= root;
		key_value    <= key;
		parent_index <= par;
		goes_left    <= left;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Pick a value in [lo, hi], favoring the ends now and then
	function automatic logic [KEY_W-1:0] pick_between(input logic [KEY_W-1:0] lo,
			input logic [KEY_W-1:0] hi);
		logic [KEY_W-1:0] span;
		logic [KEY_W-1:0] r;
		span = hi - lo;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       r = '0;
			1:       r = span;
			default: if (span != '1) r = r % (span + 1'b1);
		endcase
		return lo + r;
	endfunction

	// Add a node that keeps the search order, under a random earlier parent
	task automatic send_child();
		int unsigned      top;
		logic [IDX_W-1:0] par;
		logic [KEY_W-1:0] pk;
		logic [KEY_W-1:0] key;
		logic             left;
		logic             left_ok;
		logic             right_ok;
		top = (next_slot >= CNT_FULL) ? MAX_NODES - 1 : next_slot - 1;
		par = IDX_W'($urandom_range(1, top));
		pk = shadow_tbl[par].key;
		left_ok = (pk != KEY_MIN) && ($signed(shadow_tbl[par].lo) <= $signed(pk - 1'b1));
		right_ok = ($signed(pk) <= $signed(shadow_tbl[par].hi));
		left = 1'($urandom_range(0, 1));
		if (left && !left_ok)
			left = 1'b0;
		else if (!left && !right_ok)
			left = 1'b1;
		if (left && left_ok)
			key = pick_between(shadow_tbl[par].lo, pk - 1'b1);
		else if (!left && right_ok)
			key = pick_between(pk, shadow_tbl[par].hi);
		else
			key = {$urandom, $urandom};
		send_node(1'b0, key, par, left);
	endtask

	// Add a node with arbitrary key, parent and side
	task automatic send_noise();
		send_node(1'b0, {$urandom, $urandom}, IDX_W'($urandom_range(0, MAX_NODES - 1)),
			1'($urandom_range(0, 1)));
	endtask

	// Nodes before any root and with parent zero
	task automatic test_orphan_nodes();
		send_node(1'b0, 64'h0123_4567_89AB_CDEF, IDX_W'(1), 1'b1);
		send_node(1'b0, 64'd5, '0, 1'b0);
	endtask

	// Key extremes, equal keys, bound violations and bad parents
	task automatic test_ordering_edges();
		send_node(1'b1, KEY_MIN, '0, 1'b0);
		send_node(1'b0, KEY_MIN, IDX_W'(1), 1'b0);
		send_node(1'b0, KEY_MAX, IDX_W'(2), 1'b0);
		send_node(1'b0, KEY_MIN, IDX_W'(1), 1'b1);
		send_node(1'b0, KEY_MAX, IDX_W'(3), 1'b0);

		send_node(1'b1, KEY_MAX, '0, 1'b1);
		send_node(1'b0, KEY_MAX - 1'b1, IDX_W'(1), 1'b1);
		send_node(1'b0, KEY_MIN, IDX_W'(2), 1'b1);
		send_node(1'b0, KEY_MAX - 1'b1, IDX_W'(3), 1'b0);

		// right child of a left child bumps into the inherited upper bound
		send_node(1'b1, 64'd100, '0, 1'b0);
		send_node(1'b0, 64'd50, IDX_W'(1), 1'b1);
		send_node(1'b0, 64'd99, IDX_W'(2), 1'b0);
		send_node(1'b0, 64'd100, IDX_W'(2), 1'b0);

		// left child of a right child bumps into the inherited lower bound
		send_node(1'b1, 64'd100, '0, 1'b0);
		send_node(1'b0, 64'd200, IDX_W'(1), 1'b0);
		send_node(1'b0, 64'd100, IDX_W'(2), 1'b1);
		send_node(1'b0, 64'd99, IDX_W'(2), 1'b1);

		send_node(1'b1, '0, '0, 1'b0);
		send_node(1'b0, '0, IDX_W'(1), 1'b1);

		// parent equal to or beyond the node's own index
		send_node(1'b1, '1, '1, 1'b1);
		send_node(1'b0, '1, IDX_W'(2), 1'b0);
		send_node(1'b1, '0, '0, 1'b0);
		send_node(1'b0, '1, '1, 1'b1);
	endtask

	// Random trees, mostly well ordered, some with broken nodes mixed in
	task automatic test_random_trees();
		int unsigned sent;
		int unsigned nodes;
		bit          noisy;
		sent = 0;
		while (sent < 80) begin
			nodes = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 30) : $urandom_range(40, 79);
			if (nodes > 79 - sent)
				nodes = 79 - sent;
			noisy = 1'($urandom_range(0, 1));
			sender_steady = ($urandom_range(0, 3) == 0);
			send_node(1'b1, {$urandom, $urandom}, IDX_W'($urandom), 1'($urandom_range(0, 1)));
			repeat (nodes) begin
				if (noisy && $urandom_range(0, 9) == 0)
					send_noise();
				else
					send_child();
			end
			sent += nodes + 1;
		end
		sender_steady = 1'b0;
	endtask

	// Hold off the receiver while items keep coming so the input stalls
	task automatic test_input_stall();
		sender_steady = 1'b1;
		send_node(1'b1, {$urandom, $urandom}, '0, 1'b0);
		hold_off_req = 1'b1;
		repeat (40) send_child();
		sender_steady = 1'b0;
	endtask

	// Fill the table, overflow it, then recover with a new root
	task automatic test_table_full();
		send_node(1'b1, {$urandom, $urandom}, '0, 1'b0);
		for (int n = 0; n < MAX_NODES - 2; n++) begin
			if (n % 100 == 0)
				sender_steady = 1'($urandom_range(0, 1));
			send_child();
		end
		repeat (3) send_child();
		send_noise();
		sender_steady = 1'b0;
		send_node(1'b1, {$urandom, $urandom}, '0, 1'b1);
		send_child();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_orphan_nodes();
		test_ordering_edges();
		test_random_trees();
		test_input_stall();
		test_table_full();

		// drain outstanding results
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && verdict_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#4_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule

### sim.f
rtl/bstv_pkg.sv
rtl/bst_incremental_validator_unit.sv
tb/tb.sv
